/* hw/rtl/reliable_stream_receiver_macros.svh */
// assertion macros shared by the receiver rtl
`ifndef RELIABLE_STREAM_RECEIVER_MACROS_SVH
`define RELIABLE_STREAM_RECEIVER_MACROS_SVH

// same-cycle implication under reset
`define RSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define RSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/rsr_pkg.sv */
// types and constants of the stream receiver
`timescale 1ns / 1ps
package rsr_pkg;

	localparam logic [1:0] KIND_CONTROL = 2'd0;
	localparam logic [1:0] KIND_DELIVER = 2'd1;
	localparam logic [1:0] KIND_CLOSED  = 2'd2;

	localparam logic [31:0] INIT_SEQ_RESET = 32'd154;

	typedef struct packed {
		logic        in_syn;
		logic        in_ack_flag;
		logic        in_fin;
		logic [31:0] in_sequence;
		logic [31:0] in_acknowledge;
		logic [15:0] in_length;
	} seg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] out_sequence;
		logic [31:0] out_acknowledge;
		logic        out_syn;
		logic        out_fin;
		logic [31:0] deliver_sequence;
		logic [15:0] deliver_length;
		logic        last;
		logic [31:0] bytes_total;
		logic [31:0] segments_total;
		logic [31:0] duplicates_total;
	} res_t;

	typedef struct packed {
		logic [31:0] start;
		logic [15:0] length;
	} hold_t;

endpackage

/* hw/rtl/rsr_hold_mem.sv */
// descriptor store: one write port, one registered read port
`timescale 1ns / 1ps
module rsr_hold_mem import rsr_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  hold_t         wdata,
	input  logic [AW-1:0] raddr,
	output hold_t         rdata
);

	hold_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/rsr_out_buf.sv */
// result output register
`timescale 1ns / 1ps
module rsr_out_buf import rsr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic free,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	logic valid_q;
	res_t data_q;

	assign free      = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule

/* hw/rtl/reliable_stream_receiver.sv */
// stream receiver top level: connection control, store scans and results
//
// channel  direction  handshake              request
// seg      in         seg_valid / seg_stall  one segment header (seg_t)
// res      out        res_valid / res_stall  one result (res_t)
// cfg      in         cfg_valid / cfg_ready  initial sequence number
//
// control segments are handled in S_IDLE, with S_REPLY added for a reply
// a data segment in the window scans the store once for a duplicate, once per delivery
// and once more that finds none, each scan through the single read port of the store
// reset clears the valid bits at once, no clearing pass
// a stalled result holds the block before the next result only
`timescale 1ns / 1ps
`include "reliable_stream_receiver_macros.svh"
module reliable_stream_receiver import rsr_pkg::*; #(
	parameter int HOLD_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seg_valid,
	output logic        seg_stall,
	input  seg_t        seg_data,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int AW = (HOLD_ENTRIES > 1) ? $clog2(HOLD_ENTRIES) : 1;
	localparam int CW = $clog2(HOLD_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_DUPSCAN, S_DELSCAN, S_DELIVER, S_REPLY
	} state_t;

	typedef enum logic [1:0] {
		C_LISTEN, C_SYNRCVD, C_ESTAB, C_LASTACK
	} conn_t;

	state_t state_q;
	conn_t  conn_q;
	logic [31:0] init_q, loc_q, exp_q;
	logic [31:0] bytes_q, segs_q, dups_q;
	logic [HOLD_ENTRIES-1:0] valid_q;
	logic [31:0] key_q;
	logic [15:0] len_q;
	logic [CW-1:0] cnt_q;
	logic p_s1;
	logic [AW-1:0] p_idx_s1;
	logic [31:0] del_start_q;
	logic [15:0] del_len_q;
	logic [AW-1:0] del_idx_q;
	res_t reply_q;

	logic seg_acc, out_free, push, hit, scan_done, free_found, mem_we, scanning;
	logic [AW-1:0] free_idx;
	hold_t rd_data;
	hold_t wr_entry;
	res_t push_data;
	res_t idle_reply;
	res_t ack_reply;
	logic [31:0] bytes_next;

	assign cfg_ready = 1'b1;
	assign seg_stall = (state_q != S_IDLE);
	assign seg_acc   = seg_valid && !seg_stall;
	assign hit       = p_s1 && valid_q[p_idx_s1] && (rd_data.start == key_q);
	assign scan_done = !p_s1 && (cnt_q == CW'(HOLD_ENTRIES));
	assign mem_we    = (state_q == S_DUPSCAN) && scan_done && free_found;
	assign scanning  = (state_q == S_DUPSCAN || state_q == S_DELSCAN) && !hit && !scan_done;
	assign bytes_next = bytes_q + {16'd0, del_len_q};
	assign wr_entry.start  = key_q;
	assign wr_entry.length = len_q;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = HOLD_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	always_comb begin
		idle_reply = '0;
		idle_reply.last = 1'b1;
		idle_reply.bytes_total = bytes_q;
		idle_reply.segments_total = segs_q;
		idle_reply.duplicates_total = dups_q;
		case (conn_q)
			C_LISTEN: begin
				idle_reply.kind = KIND_CONTROL;
				idle_reply.out_sequence = init_q;
				idle_reply.out_acknowledge = seg_data.in_sequence + 32'd1;
				idle_reply.out_syn = 1'b1;
			end
			C_ESTAB: begin
				idle_reply.kind = KIND_CONTROL;
				idle_reply.out_sequence = loc_q;
				idle_reply.out_acknowledge = exp_q + 32'd1;
				idle_reply.out_fin = 1'b1;
			end
			default: begin
				idle_reply.kind = KIND_CLOSED;
			end
		endcase
	end

	always_comb begin
		ack_reply = '0;
		ack_reply.kind = KIND_CONTROL;
		ack_reply.out_sequence = loc_q;
		ack_reply.out_acknowledge = exp_q;
		ack_reply.last = 1'b1;
		ack_reply.bytes_total = bytes_q;
		ack_reply.segments_total = segs_q;
		ack_reply.duplicates_total = dups_q;
	end

	always_comb begin
		push      = 1'b0;
		push_data = reply_q;
		case (state_q)
			S_REPLY: begin
				push = out_free;
			end
			S_DELIVER: begin
				push = out_free;
				push_data = '0;
				push_data.kind = KIND_DELIVER;
				push_data.deliver_sequence = del_start_q;
				push_data.deliver_length = del_len_q;
				push_data.bytes_total = bytes_next;
				push_data.segments_total = segs_q;
				push_data.duplicates_total = dups_q;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	rsr_hold_mem #(.ENTRIES(HOLD_ENTRIES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (free_idx),
		.wdata (wr_entry),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rd_data)
	);

	rsr_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.free      (out_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			conn_q  <= C_LISTEN;
			init_q  <= INIT_SEQ_RESET;
			loc_q   <= INIT_SEQ_RESET;
			exp_q   <= '0;
			bytes_q <= '0;
			segs_q  <= '0;
			dups_q  <= '0;
			valid_q <= '0;
			cnt_q   <= '0;
			p_s1    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				init_q <= cfg_data;
			end
			if (scanning) begin
				if (cnt_q < CW'(HOLD_ENTRIES)) begin
					cnt_q <= cnt_q + 1'b1;
					p_s1 <= 1'b1;
				end else begin
					p_s1 <= 1'b0;
				end
				p_idx_s1 <= cnt_q[AW-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (seg_acc) begin
						reply_q <= idle_reply;
						key_q <= seg_data.in_sequence;
						len_q <= seg_data.in_length;
						cnt_q <= '0;
						p_s1 <= 1'b0;
						case (conn_q)
							C_LISTEN: begin
								if (seg_data.in_syn) begin
									loc_q <= init_q + 32'd1;
									exp_q <= seg_data.in_sequence + 32'd1;
									conn_q  <= C_SYNRCVD;
									state_q <= S_REPLY;
								end
							end
							C_SYNRCVD: begin
								if (seg_data.in_ack_flag && seg_data.in_acknowledge == loc_q) begin
									conn_q <= C_ESTAB;
								end
							end
							C_ESTAB: begin
								if (seg_data.in_fin) begin
									exp_q <= exp_q + 32'd1;
									loc_q <= loc_q + 32'd1;
									conn_q  <= C_LASTACK;
									state_q <= S_REPLY;
								end else if (((seg_data.in_sequence - exp_q) >> 31) != 32'd0) begin
									dups_q <= dups_q + 32'd1;
								end else begin
									state_q <= S_DUPSCAN;
								end
							end
							default: begin
								if (seg_data.in_ack_flag && seg_data.in_acknowledge == loc_q) begin
									valid_q <= '0;
									conn_q  <= C_LISTEN;
									state_q <= S_REPLY;
								end
							end
						endcase
					end
				end
				S_DUPSCAN: begin
					if (hit) begin
						dups_q  <= dups_q + 32'd1;
						p_s1    <= 1'b0;
						state_q <= S_IDLE;
					end else if (scan_done) begin
						if (free_found) begin
							valid_q[free_idx] <= 1'b1;
							segs_q <= segs_q + 32'd1;
						end
						key_q   <= exp_q;
						cnt_q   <= '0;
						p_s1    <= 1'b0;
						state_q <= S_DELSCAN;
					end
				end
				S_DELSCAN: begin
					if (hit) begin
						del_start_q <= rd_data.start;
						del_len_q   <= rd_data.length;
						del_idx_q   <= p_idx_s1;
						p_s1        <= 1'b0;
						state_q     <= S_DELIVER;
					end else if (scan_done) begin
						reply_q <= ack_reply;
						state_q <= S_REPLY;
					end
				end
				S_DELIVER: begin
					if (out_free) begin
						valid_q[del_idx_q] <= 1'b0;
						exp_q   <= exp_q + {16'd0, del_len_q};
						key_q   <= exp_q + {16'd0, del_len_q};
						bytes_q <= bytes_next;
						cnt_q   <= '0;
						p_s1    <= 1'b0;
						state_q <= S_DELSCAN;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`RSR_ASSERT_NOW(a_push_free, clk, arst_n, push, out_free, "result pushed into a full register")
	`RSR_ASSERT_NEXT(a_hit_deliver, clk, arst_n, (state_q == S_DELSCAN) && hit, state_q == S_DELIVER, "store hit not delivered")
	`RSR_ASSERT_NOW(a_deliver_kind, clk, arst_n, push && (state_q == S_DELIVER), push_data.kind == KIND_DELIVER && !push_data.last, "delivery result malformed")
	`RSR_ASSERT_NEXT(a_write_valid, clk, arst_n, mem_we, valid_q[$past(free_idx)], "written entry not marked valid")

endmodule

/* tb/reliable_stream_receiver_test.sv */
// testbench of the stream receiver: directed and random segments, checked against a predictor
`timescale 1ns / 1ps
module reliable_stream_receiver_test;
	import rsr_pkg::*;

	typedef enum logic [1:0] {LISTEN, SYN_RCVD, ESTABLISHED, CLOSING} conn_e;

	typedef struct {
		seg_t seg;
		bit   typed;
		res_t want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        seg_valid = 1'b0;
	logic        seg_stall;
	seg_t        seg_data = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	// receiver state as tracked by the testbench
	logic [31:0] init_seq;
	conn_e       conn;
	logic [31:0] local_seq;
	logic [31:0] exp_seq;
	hold_t       held [16];
	bit          held_on [16];
	logic [31:0] byte_cnt;
	logic [31:0] seg_cnt;
	logic [31:0] dup_cnt;

	res_t  pending [$];
	res_t  fresh [$];
	hold_t pool [$];
	bit    flood;
	bit    typed_on;
	res_t  typed_res;
	int    handled;
	int    errors;
	int    send_idle;
	int    recv_idle;

	reliable_stream_receiver u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg_data(seg_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int held_slot(logic [31:0] st);
		for (int i = 0; i < 16; i++) begin
			if (held_on[i] && held[i].start == st) return i;
		end
		return -1;
	endfunction

	function automatic void add_result(logic [1:0] kind, logic [31:0] oseq, logic [31:0] oack,
			logic syn, logic fin, logic [31:0] dseq, logic [15:0] dlen);
		res_t r;
		r = '{kind, oseq, oack, syn, fin, dseq, dlen, 1'b0, byte_cnt, seg_cnt, dup_cnt};
		fresh.push_back(r);
	endfunction

	// returns 1 when the segment changes anything or draws a result
	function automatic bit track_segment(seg_t s);
		logic [31:0] gap;
		int slot;
		res_t r;
		bit acted;
		acted = 1'b0;
		fresh.delete();
		case (conn)
			LISTEN: begin
				if (s.in_syn) begin
					local_seq = init_seq;
					exp_seq = s.in_sequence + 32'd1;
					add_result(KIND_CONTROL, local_seq, exp_seq, 1'b1, 1'b0, '0, '0);
					local_seq = local_seq + 32'd1;
					conn = SYN_RCVD;
					acted = 1'b1;
				end
			end
			SYN_RCVD: begin
				if (s.in_ack_flag && s.in_acknowledge == local_seq) begin
					conn = ESTABLISHED;
					acted = 1'b1;
				end
			end
			ESTABLISHED: begin
				acted = 1'b1;
				gap = s.in_sequence - exp_seq;
				if (s.in_fin) begin
					exp_seq = exp_seq + 32'd1;
					add_result(KIND_CONTROL, local_seq, exp_seq, 1'b0, 1'b1, '0, '0);
					local_seq = local_seq + 32'd1;
					conn = CLOSING;
				end else if (gap[31] || held_slot(s.in_sequence) >= 0) begin
					dup_cnt = dup_cnt + 32'd1;
				end else begin
					slot = -1;
					for (int i = 15; i >= 0; i--) begin
						if (!held_on[i]) slot = i;
					end
					if (slot >= 0) begin
						seg_cnt = seg_cnt + 32'd1;
						held[slot] = '{s.in_sequence, s.in_length};
						held_on[slot] = 1'b1;
					end
					slot = held_slot(exp_seq);
					while (slot >= 0) begin
						held_on[slot] = 1'b0;
						exp_seq = exp_seq + {16'd0, held[slot].length};
						byte_cnt = byte_cnt + {16'd0, held[slot].length};
						add_result(KIND_DELIVER, '0, '0, 1'b0, 1'b0, held[slot].start,
							held[slot].length);
						slot = held_slot(exp_seq);
					end
					add_result(KIND_CONTROL, local_seq, exp_seq, 1'b0, 1'b0, '0, '0);
				end
			end
			default: begin
				if (s.in_ack_flag && s.in_acknowledge == local_seq) begin
					for (int i = 0; i < 16; i++) held_on[i] = 1'b0;
					conn = LISTEN;
					add_result(KIND_CLOSED, '0, '0, 1'b0, 1'b0, '0, '0);
					acted = 1'b1;
				end
			end
		endcase
		if (fresh.size() > 0) begin
			r = fresh.pop_back();
			r.last = 1'b1;
			fresh.push_back(r);
		end
		return acted;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (pending.size() == 0) begin
					$display("%0t unexpected result expected none actual %p", $time, res_data);
					errors++;
				end else begin
					res_t w;
					w = pending.pop_front();
					check_field("kind", 32'(w.kind), 32'(res_data.kind));
					check_field("out_sequence", w.out_sequence, res_data.out_sequence);
					check_field("out_acknowledge", w.out_acknowledge, res_data.out_acknowledge);
					check_field("out_syn", 32'(w.out_syn), 32'(res_data.out_syn));
					check_field("out_fin", 32'(w.out_fin), 32'(res_data.out_fin));
					check_field("deliver_sequence", w.deliver_sequence, res_data.deliver_sequence);
					check_field("deliver_length", 32'(w.deliver_length),
						32'(res_data.deliver_length));
					check_field("last", 32'(w.last), 32'(res_data.last));
					check_field("bytes_total", w.bytes_total, res_data.bytes_total);
					check_field("segments_total", w.segments_total, res_data.segments_total);
					check_field("duplicates_total", w.duplicates_total, res_data.duplicates_total);
				end
			end
			if (seg_valid && !seg_stall) begin
				if (track_segment(seg_data)) handled++;
				if (typed_on) pending.push_back(typed_res);
				else foreach (fresh[i]) pending.push_back(fresh[i]);
			end
		end
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	function automatic seg_t mk(int syn, int ackf, int fin, logic [31:0] sq,
			logic [31:0] an, logic [15:0] ln);
		seg_t s;
		s = '{syn[0], ackf[0], fin[0], sq, an, ln};
		return s;
	endfunction

	function automatic seg_t gen_segment();
		seg_t s;
		hold_t h;
		logic [31:0] at;
		int k;
		s = mk($urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
		if ($urandom_range(0, 99) < 12) return s;
		s.in_syn = 1'b0;
		s.in_ack_flag = 1'b0;
		s.in_fin = 1'b0;
		case (conn)
			LISTEN: begin
				pool.delete();
				flood = ($urandom_range(0, 3) == 0);
				s.in_syn = 1'b1;
				if ($urandom_range(0, 3) == 0) s.in_sequence = 32'hFFFF_FFFF - $urandom_range(0, 40);
			end
			ESTABLISHED: begin
				if (pool.size() == 0 && $urandom_range(0, 19) == 0) begin
					s.in_fin = 1'b1;
					return s;
				end
				// far ahead segments that never drain and fill the store
				if ((flood && $urandom_range(0, 1) == 0) || $urandom_range(0, 24) == 0) begin
					s.in_sequence = exp_seq + $urandom_range(70000, 32'h4000_0000);
					return s;
				end
				if ($urandom_range(0, 9) == 0) begin
					s.in_sequence = exp_seq - $urandom_range(1, 1000);
					return s;
				end
				if (pool.size() == 0) begin
					k = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 16 : 5);
					at = exp_seq;
					repeat (k) begin
						h.start = at;
						h.length = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 200));
						pool.push_back(h);
						at = at + {16'd0, h.length};
					end
				end
				k = $urandom_range(0, pool.size() - 1);
				h = pool[k];
				pool.delete(k);
				s.in_sequence = h.start;
				s.in_length = h.length;
			end
			default: begin
				s.in_ack_flag = 1'b1;
				if ($urandom_range(0, 9) != 0) s.in_acknowledge = local_seq;
			end
		endcase
		return s;
	endfunction

	// entered and left at a falling edge
	task automatic push_segment(seg_t s, bit typed, res_t want);
		if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			seg_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		typed_on = typed;
		typed_res = want;
		seg_data = s;
		seg_valid = 1'b1;
		do @(posedge clk); while (seg_stall);
		@(negedge clk);
	endtask

	task automatic write_initial_sequence(logic [31:0] v);
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		init_seq = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic settle();
		seg_valid = 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	initial begin
		row_t plan [$];
		logic [31:0] cfg_values [3];
		int target;
		arst_n = 1'b0;
		init_seq = INIT_SEQ_RESET;
		conn = LISTEN;
		local_seq = INIT_SEQ_RESET;
		exp_seq = '0;
		for (int i = 0; i < 16; i++) held_on[i] = 1'b0;
		byte_cnt = '0;
		seg_cnt = '0;
		dup_cnt = '0;
		flood = 1'b0;
		typed_on = 1'b0;
		typed_res = '0;
		handled = 0;
		errors = 0;
		send_idle = 14;
		recv_idle = 51;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		plan.push_back('{mk(0, 1, 0, 32'h0, 32'd154, 16'd0), 1'b0, '0});
		plan.push_back('{mk(1, 0, 0, 32'hFFFF_FFFE, 32'h0, 16'd0), 1'b1,
			'{KIND_CONTROL, 32'd154, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 16'd0, 1'b1, 32'd0,
			32'd0, 32'd0}});
		plan.push_back('{mk(0, 1, 0, 32'h0, 32'd0, 16'd0), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'h0, 32'd155, 16'd0), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'd9, 32'd155, 16'd5), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'hFFFF_FFFF, 32'd155, 16'd10), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'hFFFF_FFFF, 32'd155, 16'd10), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'd9, 32'd155, 16'd5), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'd14, 32'd155, 16'd0), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'd14, 32'd155, 16'hFFFF), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'h0010_0000, 32'd155, 16'd1), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'h0010_0000, 32'd155, 16'd1), 1'b0, '0});
		plan.push_back('{mk(1, 1, 1, 32'h0, 32'hFFFF_FFFF, 16'd100), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'h0, 32'd155, 16'd0), 1'b0, '0});
		plan.push_back('{mk(0, 0, 0, 32'h0, 32'd157, 16'd0), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'h0, 32'd157, 16'd0), 1'b0, '0});
		plan.push_back('{mk(1, 1, 1, 32'h0, 32'h0, 16'd0), 1'b0, '0});
		plan.push_back('{mk(0, 1, 0, 32'h0, 32'd155, 16'd0), 1'b0, '0});
		foreach (plan[i]) push_segment(plan[i].seg, plan[i].typed, plan[i].want);
		typed_on = 1'b0;

		cfg_values[0] = 32'hFFFF_FFFF;
		cfg_values[1] = 32'h0;
		cfg_values[2] = $urandom;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 14 : (ph == 1) ? 51 : 0;
			recv_idle = (ph == 0) ? 51 : (ph == 1) ? 14 : 0;
			settle();
			write_initial_sequence(cfg_values[ph]);
			target = handled + 100;
			while (handled < target) push_segment(gen_segment(), 1'b0, '0);
		end

		seg_valid = 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (errors == 0 && pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rsr_pkg.sv
hw/rtl/rsr_hold_mem.sv
hw/rtl/rsr_out_buf.sv
hw/rtl/reliable_stream_receiver.sv
tb/reliable_stream_receiver_test.sv
